### rtl/core/mbrs_pkg.sv
// Shared types and constants of the Modbus RTU holding register slave.
package mbrs_pkg;

    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_HOST_RD = 2'd1;
    localparam logic [1:0] OP_HOST_WR = 2'd2;

    localparam logic [7:0] FN_READ_REGS  = 8'h03;
    localparam logic [7:0] FN_WRITE_REGS = 8'h10;
    localparam logic [7:0] FN_EXC_FLAG   = 8'h80;

    localparam logic [7:0] EXC_ILLEGAL_FUNC  = 8'h01;
    localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'h02;
    localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'h03;

    localparam logic [7:0]  BCAST_ADDR   = 8'h00;
    localparam logic [7:0]  SID_RESET    = 8'h01;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam int          MIN_FRAME    = 8;
    localparam int          WR_DATA_OFS  = 7;
    localparam int          WR_OVERHEAD  = 9;
    localparam int          HDR_BYTES    = 7;
    localparam int          EXC_BYTES    = 3;
    localparam int          ECHO_BYTES   = 6;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_HOST = 1'b1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_TX    = 9'b000000100,
        S_FETCH = 9'b000001000,
        S_HOUT  = 9'b000010000,
        S_WRA   = 9'b000100000,
        S_WRB   = 9'b001000000,
        S_WRC   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        M_EXC  = 2'd0,
        M_ECHO = 2'd1,
        M_READ = 2'd2,
        M_HOST = 2'd3
    } t_mode;

    typedef struct packed {
        logic       init;
        logic       en;
        logic [7:0] data;
    } t_crc_ctl;

endpackage

### rtl/core/mbrs_crc.sv
// CRC-16 accumulator shared by frame reception and reply transmission.
module mbrs_crc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbrs_pkg::t_crc_ctl i_ctl,
    output logic [15:0]       o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc ^ {8'h00, i_ctl.data};
        for (int k = 0; k < 8; k++) begin
            if (n_crc[0]) begin
                n_crc = (n_crc >> 1) ^ mbrs_pkg::CRC_POLY;
            end else begin
                n_crc = n_crc >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= mbrs_pkg::CRC_INIT;
        end else if (i_ctl.init) begin
            r_crc <= mbrs_pkg::CRC_INIT;
        end else if (i_ctl.en) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

### rtl/core/modbus_rtu_register_slave.sv
// Modbus RTU slave serving function 3 and 16 over a file of holding registers.
// Input channel (i_valid/o_ready) carries one word per received line byte, host
// register read or host register write; i_frame_end on a line byte closes the frame.
// Output channel (o_valid/i_ready) carries reply bytes in wire order, CRC low first,
// with o_last on the final byte, or one host read word with o_kind set.
// A host read passes through the fetch and host output states to its result.
// A closing byte starts frame handling: a check state, the write states WRA, WRB
// and WRC per written register for function 16, then the reply bytes with one
// register fetch per register read, then a closing state; the single CRC accumulator
// and the one port of the register file serialize these steps. o_ready is low until
// the frame is finished. The result register lets a word wait while the next one is
// taken; a stalled receiver holds the sequencer on the pending reply byte. Reset
// makes all holding registers read as zero, clears the frame state and sets the
// station address to 1. i_cfg_wr_en writes the station address; the user must
// write it only while the block is idle, as the block does not enforce this.
module modbus_rtu_register_slave #(
    parameter int FRAME_BYTES = 64,
    parameter int REG_COUNT   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    input  logic [3:0]  i_host_index,
    input  logic [15:0] i_host_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    output logic [15:0] o_read_value
);

    localparam int BIW = $clog2(FRAME_BYTES);
    localparam int LW  = $clog2(FRAME_BYTES + 1);
    localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int CW  = $clog2(REG_COUNT + 1);
    localparam int PW  = $clog2(2 * REG_COUNT + 6);

    mbrs_pkg::t_state r_state;
    mbrs_pkg::t_mode  r_mode;

    logic [LW-1:0]  r_len;
    logic           r_ovf;
    logic [7:0]     r_sid;
    logic [7:0]     r_hdr [mbrs_pkg::HDR_BYTES];
    logic [7:0]     r_code;
    logic [PW-1:0]  r_pos;
    logic [PW-1:0]  r_n;
    logic [RIW-1:0] r_ridx;
    logic [15:0]    r_rdata;
    logic           r_rvld;
    logic           r_hoob;
    logic [BIW-1:0] r_bidx;
    logic [7:0]     r_bdata;
    logic [7:0]     r_hi;
    logic [CW-1:0]  r_k;
    logic [7:0]     r_buf [FRAME_BYTES];
    logic [15:0]    r_mem [REG_COUNT];
    logic           r_vld [REG_COUNT];

    logic           r_ovalid;
    logic           r_okind;
    logic [7:0]     r_otx;
    logic           r_olast;
    logic [15:0]    r_oval;

    mbrs_pkg::t_crc_ctl w_crc_ctl;
    logic [15:0]        w_crc;

    logic        w_accept;
    logic        w_slot_free;
    logic        w_store;
    logic [7:0]  w_hidx;
    logic        w_host_in;
    logic [7:0]  w_addr;
    logic [7:0]  w_fn;
    logic [15:0] w_start;
    logic [15:0] w_cnt;
    logic [7:0]  w_bc;
    logic        w_bcast;
    logic        w_frame_ok;
    logic        w_bad_start;
    logic        w_bad_cnt;
    logic        w_bc_bad;
    logic        w_read_ok;
    logic [15:0] w_rdata;
    logic [7:0]  w_txb;
    logic        w_tx_go;
    logic        w_tx_last;
    logic        w_fetch_next;
    logic        w_we;
    logic [RIW-1:0] w_waddr;
    logic [15:0] w_wdata;

    assign o_ready     = (r_state == mbrs_pkg::S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_slot_free = !r_ovalid || i_ready;
    assign w_store     = w_accept && (i_func == mbrs_pkg::OP_RX_BYTE) && !r_ovf
                         && (r_len != LW'(FRAME_BYTES));
    assign w_hidx      = {4'h0, i_host_index};
    assign w_host_in   = (w_hidx < 8'(REG_COUNT));

    assign w_addr      = r_hdr[0];
    assign w_fn        = r_hdr[1];
    assign w_start     = {r_hdr[2], r_hdr[3]};
    assign w_cnt       = {r_hdr[4], r_hdr[5]};
    assign w_bc        = r_hdr[6];
    assign w_bcast     = (w_addr == mbrs_pkg::BCAST_ADDR);
    assign w_frame_ok  = (r_len >= LW'(mbrs_pkg::MIN_FRAME)) && (r_len != LW'(FRAME_BYTES))
                         && ((w_addr == r_sid) || w_bcast) && (w_crc == 16'h0000);
    assign w_bad_start = (w_start >= 16'(REG_COUNT));
    assign w_bad_cnt   = (w_cnt == 16'h0000)
                         || (({1'b0, w_start} + {1'b0, w_cnt}) > 17'(REG_COUNT));
    assign w_bc_bad    = ((10'(w_bc) + 10'(mbrs_pkg::WR_OVERHEAD)) != 10'(r_len))
                         || (17'(w_bc) != {w_cnt, 1'b0});
    assign w_read_ok   = (w_fn == mbrs_pkg::FN_READ_REGS) && !w_bcast
                         && !w_bad_start && !w_bad_cnt;

    assign w_rdata   = (r_rvld && !r_hoob) ? r_rdata : 16'h0000;
    assign w_tx_go   = (r_state == mbrs_pkg::S_TX) && w_slot_free;
    assign w_tx_last = (r_pos == r_n + PW'(1));
    assign w_fetch_next = (r_mode == mbrs_pkg::M_READ) && !r_pos[0]
                          && (r_pos >= PW'(2)) && ((r_pos + PW'(1)) < r_n);

    always_comb begin
        if (r_pos == r_n) begin
            w_txb = w_crc[7:0];
        end else if (w_tx_last) begin
            w_txb = w_crc[15:8];
        end else begin
            case (r_mode)
                mbrs_pkg::M_EXC: begin
                    if (r_pos == PW'(0)) begin
                        w_txb = r_sid;
                    end else if (r_pos == PW'(1)) begin
                        w_txb = w_fn | mbrs_pkg::FN_EXC_FLAG;
                    end else begin
                        w_txb = r_code;
                    end
                end
                mbrs_pkg::M_ECHO: begin
                    w_txb = r_hdr[r_pos[2:0]];
                end
                mbrs_pkg::M_READ: begin
                    if (r_pos == PW'(0)) begin
                        w_txb = r_sid;
                    end else if (r_pos == PW'(1)) begin
                        w_txb = w_fn;
                    end else if (r_pos == PW'(2)) begin
                        w_txb = {r_hdr[5][6:0], 1'b0};
                    end else if (r_pos[0]) begin
                        w_txb = w_rdata[15:8];
                    end else begin
                        w_txb = w_rdata[7:0];
                    end
                end
                default: begin
                    w_txb = 8'h00;
                end
            endcase
        end
    end

    always_comb begin
        w_crc_ctl.init = (r_state == mbrs_pkg::S_CHECK) || (r_state == mbrs_pkg::S_DONE);
        w_crc_ctl.en   = w_store || (w_tx_go && (r_pos < r_n));
        w_crc_ctl.data = (r_state == mbrs_pkg::S_IDLE) ? i_rx_byte : w_txb;
    end

    mbrs_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crc_ctl),
        .o_crc   (w_crc)
    );

    always_comb begin
        if (r_state == mbrs_pkg::S_WRC) begin
            w_we    = 1'b1;
            w_waddr = r_ridx;
            w_wdata = {r_hi, r_bdata};
        end else begin
            w_we    = w_accept && (i_func == mbrs_pkg::OP_HOST_WR) && w_host_in;
            w_waddr = w_hidx[RIW-1:0];
            w_wdata = i_host_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (r_state == mbrs_pkg::S_FETCH) begin
            r_rdata <= r_mem[r_ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_we) begin
            r_vld[w_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mbrs_pkg::S_FETCH) begin
            r_rvld <= r_vld[r_ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_buf[r_len[BIW-1:0]] <= i_rx_byte;
        end
        if ((r_state == mbrs_pkg::S_WRA) || (r_state == mbrs_pkg::S_WRB)) begin
            r_bdata <= r_buf[r_bidx];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < mbrs_pkg::HDR_BYTES; i++) begin
            if (w_store && (r_len == LW'(i))) begin
                r_hdr[i] <= i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sid <= mbrs_pkg::SID_RESET;
        end else if (i_cfg_wr_en) begin
            r_sid <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_tx_go || ((r_state == mbrs_pkg::S_HOUT) && w_slot_free)) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tx_go) begin
            r_okind <= mbrs_pkg::KIND_TX;
            r_otx   <= w_txb;
            r_olast <= w_tx_last;
            r_oval  <= 16'h0000;
        end else if ((r_state == mbrs_pkg::S_HOUT) && w_slot_free) begin
            r_okind <= mbrs_pkg::KIND_HOST;
            r_otx   <= 8'h00;
            r_olast <= 1'b1;
            r_oval  <= w_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbrs_pkg::S_IDLE;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_mode  <= mbrs_pkg::M_EXC;
        end else begin
            case (r_state)
                mbrs_pkg::S_IDLE: begin
                    if (w_accept) begin
                        case (i_func)
                            mbrs_pkg::OP_RX_BYTE: begin
                                if (w_store) begin
                                    r_len <= r_len + LW'(1);
                                end else if (!r_ovf) begin
                                    r_ovf <= 1'b1;
                                end
                                if (i_frame_end) begin
                                    r_state <= mbrs_pkg::S_CHECK;
                                end
                            end
                            mbrs_pkg::OP_HOST_RD: begin
                                r_mode  <= mbrs_pkg::M_HOST;
                                r_ridx  <= w_hidx[RIW-1:0];
                                r_hoob  <= !w_host_in;
                                r_state <= mbrs_pkg::S_FETCH;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                mbrs_pkg::S_CHECK: begin
                    r_pos  <= '0;
                    r_hoob <= 1'b0;
                    r_mode <= w_read_ok ? mbrs_pkg::M_READ : mbrs_pkg::M_EXC;
                    r_n    <= w_read_ok ? (PW'(mbrs_pkg::EXC_BYTES)
                                           + PW'({w_cnt[CW-1:0], 1'b0}))
                                        : PW'(mbrs_pkg::EXC_BYTES);
                    if (!w_frame_ok) begin
                        r_state <= mbrs_pkg::S_DONE;
                    end else begin
                        case (w_fn)
                            mbrs_pkg::FN_READ_REGS: begin
                                if (w_bcast) begin
                                    r_state <= mbrs_pkg::S_DONE;
                                end else if (w_bad_start) begin
                                    r_code  <= mbrs_pkg::EXC_ILLEGAL_ADDR;
                                    r_state <= mbrs_pkg::S_TX;
                                end else if (w_bad_cnt) begin
                                    r_code  <= mbrs_pkg::EXC_ILLEGAL_VALUE;
                                    r_state <= mbrs_pkg::S_TX;
                                end else begin
                                    r_ridx  <= w_start[RIW-1:0];
                                    r_state <= mbrs_pkg::S_TX;
                                end
                            end
                            mbrs_pkg::FN_WRITE_REGS: begin
                                if (w_bc_bad) begin
                                    r_state <= mbrs_pkg::S_DONE;
                                end else if (w_bad_start) begin
                                    r_code  <= mbrs_pkg::EXC_ILLEGAL_ADDR;
                                    r_state <= w_bcast ? mbrs_pkg::S_DONE : mbrs_pkg::S_TX;
                                end else if (w_bad_cnt) begin
                                    r_code  <= mbrs_pkg::EXC_ILLEGAL_VALUE;
                                    r_state <= w_bcast ? mbrs_pkg::S_DONE : mbrs_pkg::S_TX;
                                end else begin
                                    r_ridx  <= w_start[RIW-1:0];
                                    r_k     <= w_cnt[CW-1:0];
                                    r_bidx  <= BIW'(mbrs_pkg::WR_DATA_OFS);
                                    r_state <= mbrs_pkg::S_WRA;
                                end
                            end
                            default: begin
                                r_code  <= mbrs_pkg::EXC_ILLEGAL_FUNC;
                                r_state <= w_bcast ? mbrs_pkg::S_DONE : mbrs_pkg::S_TX;
                            end
                        endcase
                    end
                end
                mbrs_pkg::S_TX: begin
                    if (w_slot_free) begin
                        r_pos <= r_pos + PW'(1);
                        if (w_tx_last) begin
                            r_state <= mbrs_pkg::S_DONE;
                        end else if (w_fetch_next) begin
                            r_state <= mbrs_pkg::S_FETCH;
                        end
                    end
                end
                mbrs_pkg::S_FETCH: begin
                    r_ridx  <= RIW'(r_ridx + RIW'(1));
                    r_state <= (r_mode == mbrs_pkg::M_HOST) ? mbrs_pkg::S_HOUT
                                                            : mbrs_pkg::S_TX;
                end
                mbrs_pkg::S_HOUT: begin
                    if (w_slot_free) begin
                        r_state <= mbrs_pkg::S_IDLE;
                    end
                end
                mbrs_pkg::S_WRA: begin
                    r_bidx  <= r_bidx + BIW'(1);
                    r_state <= mbrs_pkg::S_WRB;
                end
                mbrs_pkg::S_WRB: begin
                    r_hi    <= r_bdata;
                    r_bidx  <= r_bidx + BIW'(1);
                    r_state <= mbrs_pkg::S_WRC;
                end
                mbrs_pkg::S_WRC: begin
                    r_ridx <= RIW'(r_ridx + RIW'(1));
                    r_k    <= r_k - CW'(1);
                    if (r_k != CW'(1)) begin
                        r_state <= mbrs_pkg::S_WRA;
                    end else if (w_bcast) begin
                        r_state <= mbrs_pkg::S_DONE;
                    end else begin
                        r_mode  <= mbrs_pkg::M_ECHO;
                        r_n     <= PW'(mbrs_pkg::ECHO_BYTES);
                        r_state <= mbrs_pkg::S_TX;
                    end
                end
                mbrs_pkg::S_DONE: begin
                    r_len   <= '0;
                    r_ovf   <= 1'b0;
                    r_state <= mbrs_pkg::S_IDLE;
                end
                default: begin
                    r_state <= mbrs_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_kind       = r_okind;
    assign o_tx_byte    = r_otx;
    assign o_last       = r_olast;
    assign o_read_value = r_oval;

endmodule

### dv/tb_modbus_rtu_register_slave.sv
// Testbench for the Modbus RTU holding register slave: scoreboard against a built-in predictor.
`timescale 1ns / 1ps
module tb_modbus_rtu_register_slave;

    localparam int FRAME_BYTES = 64;
    localparam int REG_COUNT   = 16;
    localparam int WATCH_LIMIT = 20000;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  rx_byte;
        logic        frame_end;
        logic [3:0]  host_index;
        logic [15:0] host_value;
    } t_word_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [15:0] read_value;
    } t_word_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'd0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func = mbrs_pkg::OP_RX_BYTE;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        i_frame_end = 1'b0;
    logic [3:0]  i_host_index = 4'd0;
    logic [15:0] i_host_value = 16'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_kind;
    logic [7:0]  o_tx_byte;
    logic        o_last;
    logic [15:0] o_read_value;

    modbus_rtu_register_slave dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [7:0]  pr_buf [FRAME_BYTES];
    int          pr_len;
    logic        pr_ovf;
    logic [15:0] pr_crc;
    logic [15:0] pr_regs [REG_COUNT];
    logic [7:0]  pr_sid;
    logic [7:0]  reply_bytes [$];

    t_word_in    pending_words [$];
    t_word_out   expected_words [$];
    int          err_count = 0;
    int          in_idle_pct = 0;
    int          out_idle_pct = 0;
    int          idle_cycles = 0;
    bit          running = 1'b0;
    bit          in_taken = 1'b0;

    function automatic logic [15:0] crc_add(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ mbrs_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic emit_reply();
        logic [15:0] c;
        int n;
        c = mbrs_pkg::CRC_INIT;
        n = reply_bytes.size();
        foreach (reply_bytes[k]) c = crc_add(c, reply_bytes[k]);
        reply_bytes.push_back(c[7:0]);
        reply_bytes.push_back(c[15:8]);
        for (int k = 0; k < n + 2; k++)
            expected_words.push_back('{mbrs_pkg::KIND_TX, reply_bytes[k], k == n + 1, 16'd0});
        reply_bytes.delete();
    endtask

    task automatic emit_exception(logic bcast, logic [7:0] fn, logic [7:0] code);
        if (bcast) return;
        reply_bytes = '{pr_sid, fn | mbrs_pkg::FN_EXC_FLAG, code};
        emit_reply();
    endtask

    task automatic close_frame();
        logic [7:0] addr, fn;
        int st, cnt, bc;
        logic bcast;
        if (pr_len < mbrs_pkg::MIN_FRAME || pr_len >= FRAME_BYTES) return;
        addr = pr_buf[0];
        if (addr != pr_sid && addr != mbrs_pkg::BCAST_ADDR) return;
        if (pr_crc != 16'd0) return;
        bcast = (addr == mbrs_pkg::BCAST_ADDR);
        fn = pr_buf[1];
        st = {pr_buf[2], pr_buf[3]};
        cnt = {pr_buf[4], pr_buf[5]};
        if (fn == mbrs_pkg::FN_READ_REGS) begin
            if (bcast) return;
            if (st >= REG_COUNT) begin
                emit_exception(bcast, fn, mbrs_pkg::EXC_ILLEGAL_ADDR);
            end else if (cnt == 0 || st + cnt > REG_COUNT) begin
                emit_exception(bcast, fn, mbrs_pkg::EXC_ILLEGAL_VALUE);
            end else begin
                reply_bytes = '{pr_sid, fn, 8'(2 * cnt)};
                for (int k = 0; k < cnt; k++) begin
                    reply_bytes.push_back(pr_regs[st + k][15:8]);
                    reply_bytes.push_back(pr_regs[st + k][7:0]);
                end
                emit_reply();
            end
        end else if (fn == mbrs_pkg::FN_WRITE_REGS) begin
            bc = pr_buf[6];
            if (bc + mbrs_pkg::WR_OVERHEAD != pr_len || bc != 2 * cnt) return;
            if (st >= REG_COUNT) begin
                emit_exception(bcast, fn, mbrs_pkg::EXC_ILLEGAL_ADDR);
            end else if (cnt == 0 || st + cnt > REG_COUNT) begin
                emit_exception(bcast, fn, mbrs_pkg::EXC_ILLEGAL_VALUE);
            end else begin
                for (int k = 0; k < cnt; k++)
                    pr_regs[st + k] = {pr_buf[mbrs_pkg::WR_DATA_OFS + 2 * k],
                                       pr_buf[mbrs_pkg::WR_DATA_OFS + 1 + 2 * k]};
                if (!bcast) begin
                    reply_bytes = '{pr_buf[0], pr_buf[1], pr_buf[2], pr_buf[3],
                                    pr_buf[4], pr_buf[5]};
                    emit_reply();
                end
            end
        end else begin
            emit_exception(bcast, fn, mbrs_pkg::EXC_ILLEGAL_FUNC);
        end
    endtask

    task automatic predict_word(t_word_in w);
        case (w.func)
            mbrs_pkg::OP_RX_BYTE: begin
                if (!pr_ovf) begin
                    if (pr_len >= FRAME_BYTES) begin
                        pr_ovf = 1'b1;
                    end else begin
                        pr_buf[pr_len] = w.rx_byte;
                        pr_len++;
                        pr_crc = crc_add(pr_crc, w.rx_byte);
                    end
                end
                if (w.frame_end) begin
                    close_frame();
                    pr_len = 0;
                    pr_ovf = 1'b0;
                    pr_crc = mbrs_pkg::CRC_INIT;
                end
            end
            mbrs_pkg::OP_HOST_RD: expected_words.push_back('{mbrs_pkg::KIND_HOST, 8'd0, 1'b1,
                w.host_index < REG_COUNT ? pr_regs[w.host_index] : 16'd0});
            mbrs_pkg::OP_HOST_WR: begin
                if (w.host_index < REG_COUNT) pr_regs[w.host_index] = w.host_value;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && running) begin
            if (!i_valid || in_taken) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
                    t_word_in w;
                    w = pending_words.pop_front();
                    i_valid <= 1'b1;
                    i_func <= w.func;
                    i_rx_byte <= w.rx_byte;
                    i_frame_end <= w.frame_end;
                    i_host_index <= w.host_index;
                    i_host_value <= w.host_value;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken = i_valid && o_ready;
            if (i_valid && o_ready) begin
                predict_word('{i_func, i_rx_byte, i_frame_end, i_host_index, i_host_value});
            end
            if (o_valid && i_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", {o_tx_byte, 7'd0, o_last}, 16'd0);
                end else begin
                    t_word_out e;
                    e = expected_words.pop_front();
                    if (o_kind !== e.kind) report_mismatch("kind", o_kind, e.kind);
                    if (o_tx_byte !== e.tx_byte) report_mismatch("tx_byte", o_tx_byte, e.tx_byte);
                    if (o_last !== e.last) report_mismatch("last", o_last, e.last);
                    if (o_read_value !== e.read_value)
                        report_mismatch("read_value", o_read_value, e.read_value);
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCH_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic t_word_in rx_word(logic [7:0] b, logic fe);
        return '{mbrs_pkg::OP_RX_BYTE, b, fe, 4'($urandom), 16'($urandom)};
    endfunction

    task automatic push_frame(logic [7:0] body [$], bit good_crc);
        logic [15:0] c;
        c = mbrs_pkg::CRC_INIT;
        foreach (body[k]) c = crc_add(c, body[k]);
        if (!good_crc) c = c ^ 16'h0101;
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        foreach (body[k]) pending_words.push_back(rx_word(body[k], k == body.size() - 1));
    endtask

    task automatic push_read(logic [7:0] addr, int st, int cnt, bit good_crc);
        push_frame('{addr, mbrs_pkg::FN_READ_REGS, 8'(st >> 8), 8'(st), 8'(cnt >> 8),
                     8'(cnt)}, good_crc);
    endtask

    task automatic push_write(logic [7:0] addr, int st, int cnt, int bc, int nbytes);
        logic [7:0] body [$];
        body = '{addr, mbrs_pkg::FN_WRITE_REGS, 8'(st >> 8), 8'(st), 8'(cnt >> 8), 8'(cnt),
                 8'(bc)};
        for (int k = 0; k < nbytes; k++) body.push_back(8'($urandom));
        push_frame(body, 1'b1);
    endtask

    task automatic push_host(logic [1:0] f, logic [3:0] idx, logic [15:0] v);
        pending_words.push_back('{f, 8'($urandom), 1'($urandom), idx, v});
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_words.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_sid(logic [7:0] v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        pr_sid = v;
    endtask

    task automatic random_traffic(int n, logic [7:0] sid);
        int kind, st, cnt;
        logic [7:0] addr;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            addr = ($urandom_range(9) == 0) ? mbrs_pkg::BCAST_ADDR :
                   ($urandom_range(9) == 0) ? 8'($urandom) : sid;
            st = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(REG_COUNT);
            cnt = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(REG_COUNT);
            if (kind < 30) begin
                push_read(addr, st, cnt, $urandom_range(9) != 0);
            end else if (kind < 55) begin
                cnt = $urandom_range(1, 6);
                push_write(addr, st, cnt, 2 * cnt,
                           ($urandom_range(9) == 0) ? 2 * cnt + 1 : 2 * cnt);
            end else if (kind < 65) begin
                push_frame('{addr, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom)}, 1'b1);
            end else if (kind < 75) begin
                push_host(mbrs_pkg::OP_HOST_RD, 4'($urandom), 16'($urandom));
            end else if (kind < 85) begin
                push_host(mbrs_pkg::OP_HOST_WR, 4'($urandom), 16'($urandom));
            end else if (kind < 90) begin
                push_host(OP_RESERVED, 4'($urandom), 16'($urandom));
            end else begin
                cnt = $urandom_range(1, 12);
                for (int k = 0; k < cnt; k++)
                    pending_words.push_back(rx_word(8'($urandom), k == cnt - 1));
            end
        end
    endtask

    initial begin
        logic [7:0] long_frame [$];
        pr_len = 0;
        pr_ovf = 1'b0;
        pr_crc = mbrs_pkg::CRC_INIT;
        pr_sid = mbrs_pkg::SID_RESET;
        foreach (pr_regs[k]) pr_regs[k] = 16'd0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_sid(8'd1);
        running = 1'b1;
        in_idle_pct = 8;
        out_idle_pct = 82;

        // directed
        push_host(mbrs_pkg::OP_HOST_WR, 4'd0, 16'hFFFF);
        push_host(mbrs_pkg::OP_HOST_WR, 4'd15, 16'h8001);
        push_host(mbrs_pkg::OP_HOST_RD, 4'd15, 16'h0);
        push_host(OP_RESERVED, 4'd5, 16'h1234);
        push_read(8'd1, 0, 16, 1'b1);
        push_read(8'd1, 16, 1, 1'b1);
        push_read(8'd1, 15, 2, 1'b1);
        push_read(8'd1, 0, 0, 1'b1);
        push_read(mbrs_pkg::BCAST_ADDR, 0, 1, 1'b1);
        push_read(8'd1, 0, 1, 1'b0);
        push_write(8'd1, 14, 2, 4, 4);
        push_write(mbrs_pkg::BCAST_ADDR, 3, 1, 2, 2);
        push_write(8'd1, 3, 1, 4, 2);
        push_write(8'd1, 3, 2, 4, 5);
        push_write(8'd1, 16, 1, 2, 2);
        push_write(8'd1, 15, 2, 4, 4);
        push_frame('{8'd1, 8'h07, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1);
        push_frame('{mbrs_pkg::BCAST_ADDR, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1);
        push_frame('{8'd1, mbrs_pkg::FN_READ_REGS, 8'd0, 8'd0, 8'd1}, 1'b1);
        for (int k = 0; k < 66; k++) long_frame.push_back(8'($urandom));
        foreach (long_frame[k]) pending_words.push_back(rx_word(long_frame[k], k == 65));
        push_read(8'd1, 0, 16, 1'b1);
        drain();

        write_sid(8'd247);
        random_traffic(3, 8'd247);
        drain();

        // sparse input with a mostly ready receiver
        write_sid(8'd1);
        in_idle_pct = 82;
        out_idle_pct = 8;
        random_traffic(3, 8'd1);
        drain();

        write_sid(8'($urandom_range(2, 246)));
        in_idle_pct = 0;
        out_idle_pct = 0;
        random_traffic(3, pr_sid);
        drain();

        if (err_count == 0 && expected_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### sim.f
rtl/core/mbrs_pkg.sv
rtl/core/mbrs_crc.sv
rtl/core/modbus_rtu_register_slave.sv
dv/tb_modbus_rtu_register_slave.sv
